FILE: src/pud_pkg.sv
// ----------------------------------------------------------------------------
// pud_pkg
// Shared types and character constants for the percent URL decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pud_pkg;

  localparam int PUD_QDEPTH = 4;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // one queued command: dual emits a literal percent ahead of data
  typedef struct packed {
    logic       dual;
    logic [7:0] data;
    logic       last;
  } pud_entry_t;

endpackage

`default_nettype wire

FILE: src/pud_front.sv
// ----------------------------------------------------------------------------
// pud_front
// Accepts encoded bytes, tracks the escape phase and builds decode commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pud_front
  import pud_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output pud_entry_t      ent,
  output logic            ent_vld
);

  localparam logic [1:0] PH_PLAIN = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIG   = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] parse_pair(input logic [7:0] c1, input logic [7:0] c2);
    logic [4:0] d1;
    logic [4:0] d2;
    logic [7:0] r;
    d1 = hex_val(c1);
    d2 = hex_val(c2);
    r  = 8'd0;
    if (c1 == 8'd0) begin
      r = 8'd0;
    end else if (is_ws(c1) || c1 == CH_PLUS) begin
      r = d2[4] ? {4'd0, d2[3:0]} : 8'd0;
    end else if (c1 == 8'h2D) begin
      r = d2[4] ? 8'(-{4'd0, d2[3:0]}) : 8'd0;
    end else if (d1[4]) begin
      r = d2[4] ? {d1[3:0], d2[3:0]} : {4'd0, d1[3:0]};
    end
    return r;
  endfunction

  function automatic logic [7:0] plain_map(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

  always_comb begin
    ent_vld   = 1'b0;
    ent.dual  = 1'b0;
    ent.data  = plain_map(in_byte);
    ent.last  = in_last;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    case (phase_r)
      PH_PCT: begin
        if (in_last) begin
          ent_vld  = 1'b1;
          ent.dual = 1'b1;
        end else begin
          held_nxt  = in_byte;
          phase_nxt = PH_DIG;
        end
      end
      PH_DIG: begin
        ent_vld   = 1'b1;
        ent.data  = parse_pair(held_r, in_byte);
        phase_nxt = PH_PLAIN;
      end
      default: begin
        phase_nxt = PH_PLAIN;
        if (in_byte == CH_PERCENT) begin
          if (in_last) begin
            ent_vld  = 1'b1;
            ent.data = CH_PERCENT;
          end else begin
            phase_nxt = PH_PCT;
          end
        end else begin
          ent_vld = 1'b1;
        end
      end
    endcase
    if (in_last) begin
      phase_nxt = PH_PLAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      held_r  <= 8'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/pud_queue.sv
// ----------------------------------------------------------------------------
// pud_queue
// Small circular command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module pud_queue
  import pud_pkg::*;
#(
  parameter int QDEPTH = PUD_QDEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_en,
  input  wire pud_entry_t wr_data,
  input  wire logic       rd_en,
  output pud_entry_t      rd_data,
  output logic            full,
  output logic            empty
);

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  pud_entry_t      mem [QDEPTH];
  logic [AW-1:0]   wptr_r, wptr_nxt;
  logic [AW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_wr, do_rd;

  assign full    = (count_r == CW'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == AW'(QDEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == AW'(QDEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QDEPTH))
    else $error("queue count above depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CW'(QDEPTH)) |-> (wptr_r == rptr_r))
    else $error("queue pointers disagree with count");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count did not advance on write");
`endif

endmodule

`default_nettype wire

FILE: src/pud_back.sv
// ----------------------------------------------------------------------------
// pud_back
// Expands queued commands into result transactions from an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pud_back
  import pud_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire pud_entry_t q_data,
  input  wire logic       q_empty,
  output logic            q_rd,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            out_string_end,
  output logic            out_run_end
);

  pud_entry_t cur_r;
  logic       vld_r, vld_nxt;
  logic       sub_r, sub_nxt;
  logic       take, done, load;

  assign take  = pop && vld_r;
  assign done  = take && (!cur_r.dual || sub_r);
  assign load  = !vld_r || done;
  assign q_rd  = load && !q_empty;
  assign empty = !vld_r;

  always_comb begin
    if (cur_r.dual && !sub_r) begin
      out_byte       = CH_PERCENT;
      out_string_end = 1'b0;
      out_run_end    = 1'b0;
    end else begin
      out_byte       = cur_r.data;
      out_string_end = cur_r.last;
      out_run_end    = 1'b1;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    sub_nxt = sub_r;
    if (load) begin
      vld_nxt = !q_empty;
      sub_nxt = 1'b0;
    end else if (take) begin
      sub_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sub_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      sub_r <= sub_nxt;
    end
  end

`ifndef SYNTHESIS
  a_sub_dual: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (vld_r && cur_r.dual))
    else $error("second result without a dual command");
`endif

endmodule

`default_nettype wire

FILE: src/percent_url_decoder.sv
// ----------------------------------------------------------------------------
// percent_url_decoder
// Streaming URL percent decoder, one encoded byte per transaction.
// ----------------------------------------------------------------------------
// Takes one encoded byte per cycle; push is refused only while the command
// queue (QDEPTH entries) is full. Each byte yields zero, one or two decoded
// bytes: a percent escape yields one byte on its second digit, and a percent
// followed by the last byte of a string yields two, which leave the output
// register one pop at a time. Sustained output is one result per cycle while
// pop is held and the queue holds commands, set by the single output register
// in the back part; a result is written into the command queue, then loaded
// into the output register, and can be popped only once it is held there.
`default_nettype none

module percent_url_decoder
  import pud_pkg::*;
#(
  parameter int QDEPTH = PUD_QDEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_string_end,
  output logic            out_run_end
);

  pud_entry_t f_ent;
  pud_entry_t q_data;
  logic       f_vld;
  logic       accept;
  logic       q_empty;
  logic       q_rd;

  assign accept = push && !full;

  pud_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .ent     (f_ent),
    .ent_vld (f_vld)
  );

  pud_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && f_vld),
    .wr_data (f_ent),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  pud_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_data         (q_data),
    .q_empty        (q_empty),
    .q_rd           (q_rd),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_string_end (out_string_end),
    .out_run_end    (out_run_end)
  );

endmodule

`default_nettype wire
